/* design/spgi_pkg.sv */
`default_nettype none

package spgi_pkg;

    // Field widths
    localparam int DIM_W     = 7;
    localparam int CELL_W    = 6;
    localparam int POS_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Grid size limits and reset size
    localparam int DEFAULT_MAX_DIM = 64;
    localparam int GRID_RESET      = 64;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Register indexes
    localparam cfg_index_t REG_GRID_ROWS = 2'd0;
    localparam cfg_index_t REG_GRID_COLS = 2'd1;

endpackage

`default_nettype wire

/* design/spiral_grid_index.sv */
`default_nettype none

// Maps a cell (cell_row, cell_col) of a grid_rows x grid_cols grid to its position along a
// clockwise inward spiral that starts at 0 in the top-left corner; a cell outside the grid
// returns pos_valid = 0 with spiral_pos = 0. The block is a four-stage pipeline (bound
// check, ring search, ring-length product and in-ring offset, final add); it takes one item
// every cycle and slows only when the output side holds off out_ready. Grid sizes are
// written through the cfg port (index 0 rows, index 1 columns; other indexes are ignored),
// clipped to MAX_DIM on write, and must only change while no item is in flight.
module spiral_grid_index #(
    parameter int MAX_DIM = spgi_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [spgi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spgi_pkg::DIM_W-1:0]        cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [spgi_pkg::CELL_W-1:0]       cell_row,
    input  wire logic [spgi_pkg::CELL_W-1:0]       cell_col,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [spgi_pkg::POS_W-1:0]             spiral_pos,
    output logic                                   pos_valid
);

    localparam int DIM_W  = spgi_pkg::DIM_W;
    localparam int CELL_W = spgi_pkg::CELL_W;
    localparam int POS_W  = spgi_pkg::POS_W;
    localparam int SUM_W  = DIM_W + 1;
    localparam int PROD_W = DIM_W + SUM_W;

    localparam int RESET_DIM_I =
        (spgi_pkg::GRID_RESET > MAX_DIM) ? MAX_DIM : spgi_pkg::GRID_RESET;
    localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(RESET_DIM_I);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // ------------------------------------------------------------------
    // Grid size registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RESET_DIM;
            cols_reg <= RESET_DIM;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                spgi_pkg::REG_GRID_ROWS:
                begin
                    rows_reg <= sat_dim(cfg_data);
                end
                spgi_pkg::REG_GRID_COLS:
                begin
                    cols_reg <= sat_dim(cfg_data);
                end
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: bound check, distances to bottom and right edges
    // ------------------------------------------------------------------
    logic              in1_next;
    logic [DIM_W-1:0]  db1_next, dr1_next;

    logic              in1_reg;
    logic [CELL_W-1:0] row1_reg, col1_reg;
    logic [DIM_W-1:0]  db1_reg, dr1_reg, rows1_reg, cols1_reg;

    assign in1_next = ({1'b0, cell_row} < rows_reg) && ({1'b0, cell_col} < cols_reg);
    assign db1_next = rows_reg - {1'b0, cell_row} - DIM_W'(1);
    assign dr1_next = cols_reg - {1'b0, cell_col} - DIM_W'(1);

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            in1_reg   <= in1_next;
            row1_reg  <= cell_row;
            col1_reg  <= cell_col;
            db1_reg   <= db1_next;
            dr1_reg   <= dr1_next;
            rows1_reg <= rows_reg;
            cols1_reg <= cols_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: ring number (distance to the nearest edge)
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  ring2_next;

    logic              in2_reg;
    logic [CELL_W-1:0] row2_reg, col2_reg;
    logic [DIM_W-1:0]  db2_reg, dr2_reg, rows2_reg, cols2_reg, ring2_reg;

    assign ring2_next = min_dim(min_dim({1'b0, row1_reg}, {1'b0, col1_reg}),
                                min_dim(db1_reg, dr1_reg));

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            in2_reg   <= in1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            db2_reg   <= db1_reg;
            dr2_reg   <= dr1_reg;
            rows2_reg <= rows1_reg;
            cols2_reg <= cols1_reg;
            ring2_reg <= ring2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: half the total length of the outer rings, ring*(rows+cols-2*ring),
    // and the offset within the cell's own ring
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  span3;
    logic [PROD_W-1:0] prod3_next;
    logic [POS_W-1:0]  off3_next;
    logic [POS_W-1:0]  row_e, col_e, db_e, dr_e, ring_e, w_e, hgap_e, wgap_e;

    logic              in3_reg;
    logic [PROD_W-1:0] prod3_reg;
    logic [POS_W-1:0]  off3_reg;

    assign span3      = {1'b0, rows2_reg} + {1'b0, cols2_reg} - {ring2_reg, 1'b0};
    assign prod3_next = PROD_W'(ring2_reg * span3);

    assign row_e  = POS_W'(row2_reg);
    assign col_e  = POS_W'(col2_reg);
    assign db_e   = POS_W'(db2_reg);
    assign dr_e   = POS_W'(dr2_reg);
    assign ring_e = POS_W'(ring2_reg);
    // ring width, and the spans of its right column and bottom row
    assign w_e    = POS_W'(cols2_reg) - {ring_e[POS_W-2:0], 1'b0};
    assign hgap_e = POS_W'(rows2_reg) - POS_W'(1) - {ring_e[POS_W-2:0], 1'b0};
    assign wgap_e = POS_W'(cols2_reg) - POS_W'(1) - {ring_e[POS_W-2:0], 1'b0};

    always_comb
    begin
        priority if ({1'b0, row2_reg} == ring2_reg)
        begin
            off3_next = col_e - ring_e;
        end
        else if (dr2_reg == ring2_reg)
        begin
            off3_next = w_e + row_e - ring_e - POS_W'(1);
        end
        else if (db2_reg == ring2_reg)
        begin
            off3_next = w_e + hgap_e + dr_e - ring_e - POS_W'(1);
        end
        else
        begin
            off3_next = w_e + hgap_e + wgap_e + db_e - ring_e - POS_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            in3_reg   <= in2_reg;
            prod3_reg <= prod3_next;
            off3_reg  <= off3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final add and output register
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos4_next;
    logic [POS_W-1:0] pos4_reg;
    logic             in4_reg;

    assign pos4_next = in3_reg ? (POS_W'({prod3_reg, 1'b0}) + off3_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            pos4_reg <= pos4_next;
            in4_reg  <= in3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign spiral_pos = pos4_reg;
    assign pos_valid  = in4_reg;

`ifndef SYNTH
    // the ring of an inside cell never reaches past the middle row
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && in2_reg) |-> ({1'b0, ring2_reg, 1'b0} < {2'b00, rows2_reg}))
        else $error("ring index beyond half the grid height");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pos_valid) |-> (spiral_pos == '0))
        else $error("outside cell gives a non-zero position");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en4) |=> (v3_reg && $stable(prod3_reg) && $stable(off3_reg)))
        else $error("stage 3 item lost or changed under stall");
`endif

endmodule

`default_nettype wire

/* sim/spiral_grid_checker.sv */
`timescale 1ns / 100ps

module spiral_grid_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [spgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spgi_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [spgi_pkg::CELL_W-1:0]    cell_row,
    input  wire logic [spgi_pkg::CELL_W-1:0]    cell_col,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [spgi_pkg::POS_W-1:0]     spiral_pos,
    input  wire logic                           pos_valid,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked
);

    localparam int DIM_W  = spgi_pkg::DIM_W;
    localparam int CELL_W = spgi_pkg::CELL_W;
    localparam int POS_W  = spgi_pkg::POS_W;

    typedef struct {
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        int                rows_eff;
        int                cols_eff;
        logic [POS_W-1:0]  pos;
        logic              in_grid;
    } spiral_result_t;

    logic [DIM_W-1:0] grid_rows_q;
    logic [DIM_W-1:0] grid_cols_q;
    spiral_result_t   expected_q[$];
    spiral_result_t   want;

    function automatic spiral_result_t predict_spiral(logic [CELL_W-1:0] row_in,
                                                      logic [CELL_W-1:0] col_in,
                                                      logic [DIM_W-1:0] rows_raw,
                                                      logic [DIM_W-1:0] cols_raw);
        spiral_result_t res;
        int nr, nc, r, c, ring, row_lo, col_lo, row_hi, col_hi, pos, w, h;
        nr = (rows_raw > spgi_pkg::DEFAULT_MAX_DIM) ? spgi_pkg::DEFAULT_MAX_DIM
                                                     : int'(rows_raw);
        nc = (cols_raw > spgi_pkg::DEFAULT_MAX_DIM) ? spgi_pkg::DEFAULT_MAX_DIM
                                                     : int'(cols_raw);
        r = row_in;
        c = col_in;
        res.row      = row_in;
        res.col      = col_in;
        res.rows_eff = nr;
        res.cols_eff = nc;
        res.pos      = '0;
        res.in_grid  = 1'b0;
        if (r < nr && c < nc)
        begin
            ring = (r < c) ? r : c;
            if (nr - 1 - r < ring) ring = nr - 1 - r;
            if (nc - 1 - c < ring) ring = nc - 1 - c;
            row_lo = ring;
            col_lo = ring;
            row_hi = nr - 1 - ring;
            col_hi = nc - 1 - ring;
            pos = 0;
            // add the full length of every ring outside this one
            for (int k = 0; k < ring; k++)
            begin
                w = nc - 2 * k;
                h = nr - 2 * k;
                pos += 2 * w + ((h > 2) ? 2 * (h - 2) : 0);
            end
            // walk top row, right column, bottom row, left column
            if (r == row_lo)
                pos += c - col_lo;
            else
            begin
                pos += col_hi - col_lo + 1;
                if (c == col_hi)
                    pos += r - row_lo - 1;
                else
                begin
                    if (row_hi - row_lo > 0) pos += row_hi - row_lo;
                    if (r == row_hi)
                        pos += col_hi - c - 1;
                    else
                    begin
                        if (col_hi - col_lo > 0) pos += col_hi - col_lo;
                        pos += row_hi - r - 1;
                    end
                end
            end
            res.pos     = pos[POS_W-1:0];
            res.in_grid = 1'b1;
        end
        return res;
    endfunction

    task automatic report(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_q <= DIM_W'(spgi_pkg::GRID_RESET);
            grid_cols_q <= DIM_W'(spgi_pkg::GRID_RESET);
            expected_q.delete();
            pending     <= 0;
            fail_count  = 0;
            checked     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    spgi_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data;
                    spgi_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_q.size() == 0)
                    report($sformatf("result pos %0d valid %0b with no cell outstanding",
                                     spiral_pos, pos_valid));
                else
                begin
                    want = expected_q.pop_front();
                    if (spiral_pos !== want.pos)
                        report($sformatf("cell (%0d,%0d) grid %0dx%0d: spiral_pos %0d, want %0d",
                                         want.row, want.col, want.rows_eff, want.cols_eff,
                                         spiral_pos, want.pos));
                    if (pos_valid !== want.in_grid)
                        report($sformatf("cell (%0d,%0d) grid %0dx%0d: pos_valid %0b, want %0b",
                                         want.row, want.col, want.rows_eff, want.cols_eff,
                                         pos_valid, want.in_grid));
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_spiral(cell_row, cell_col,
                                                    grid_rows_q, grid_cols_q));
            pending <= expected_q.size();
        end
    end

endmodule

/* sim/tb_spiral_grid_index.sv */
`timescale 1ns / 100ps

module tb_spiral_grid_index;

    localparam int DIM_W     = spgi_pkg::DIM_W;
    localparam int CELL_W    = spgi_pkg::CELL_W;
    localparam int POS_W     = spgi_pkg::POS_W;
    localparam int CFG_IDX_W = spgi_pkg::CFG_IDX_W;

    localparam int PIPE_DEPTH   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_CELLS  = 45;

    // indexes past the register list; writes there must be dropped
    localparam spgi_pkg::cfg_index_t REG_SPARE_A = 2'd2;
    localparam spgi_pkg::cfg_index_t REG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CELL_W-1:0]    cell_row;
    logic [CELL_W-1:0]    cell_col;
    logic                 out_valid;
    logic                 out_ready;
    logic [POS_W-1:0]     spiral_pos;
    logic                 pos_valid;

    int fail_count;
    int pending;
    int checked;
    int cells_sent;
    int grids_set;
    int burst_left;
    bit steady;
    int cycle_count;

    spiral_grid_index i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .spiral_pos (spiral_pos),
        .pos_valid  (pos_valid)
    );

    spiral_grid_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .spiral_pos (spiral_pos),
        .pos_valid  (pos_valid),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic write_reg(input spgi_pkg::cfg_index_t idx, input logic [DIM_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
        write_reg(spgi_pkg::REG_GRID_ROWS, rows);
        write_reg(spgi_pkg::REG_GRID_COLS, cols);
        grids_set++;
    endtask

    task automatic send_cell(input logic [CELL_W-1:0] r, input logic [CELL_W-1:0] c);
        int gap;
        in_valid <= 1'b1;
        cell_row <= r;
        cell_col <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cells_sent++;
        if (burst_left > 0) burst_left--;
        // end of burst: drop valid for a while
        if (!steady && burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let the pipeline empty before touching the grid size
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'($urandom_range(65, 127));
            2:       return DIM_W'(64);
            3, 4:    return DIM_W'($urandom_range(9, 63));
            default: return DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    // receiver: replay a 16-bit ready pattern, redrawn each time round
    initial
    begin
        logic [15:0] stall_pat;
        int          stall_pos;
        out_ready <= 1'b0;
        stall_pat = '1;
        stall_pos = 0;
        forever
        begin
            @(posedge clk);
            if (stall_pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom) & 16'($urandom);
                    default: stall_pat = 16'h8000;
                endcase
            end
            out_ready <= stall_pat[stall_pos];
            stall_pos = (stall_pos + 1) % 16;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, pending);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [DIM_W-1:0]  rows, cols;
        int                nr, nc;
        logic [CELL_W-1:0] r, c;
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= spgi_pkg::REG_GRID_ROWS;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        cell_row   <= '0;
        cell_col   <= '0;
        cells_sent = 0;
        grids_set  = 0;
        burst_left = 0;
        steady     = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 64x64: corners, centre ring and ring seams
        send_cell(0, 0);
        send_cell(0, 63);
        send_cell(63, 0);
        send_cell(63, 63);
        send_cell(31, 31);
        send_cell(32, 32);
        send_cell(32, 31);
        send_cell(1, 0);
        settle();

        set_grid(1, 1);
        send_cell(0, 0);
        send_cell(0, 1);
        send_cell(1, 0);
        settle();

        // zero size: nothing lies inside
        set_grid(0, 5);
        send_cell(0, 0);
        settle();
        set_grid(5, 0);
        send_cell(0, 0);
        settle();

        // oversized registers saturate to the maximum
        set_grid(127, 100);
        send_cell(63, 63);
        send_cell(63, 0);
        send_cell(0, 0);
        settle();

        set_grid(64, 1);
        send_cell(63, 0);
        send_cell(5, 1);
        settle();

        set_grid(1, 64);
        send_cell(0, 63);
        send_cell(1, 5);
        settle();

        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        send_cell(3, 3);
        send_cell(0, 63);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
            begin
                rows = DIM_W'(64);
                cols = DIM_W'(64);
            end
            else
            begin
                rows = pick_size();
                cols = pick_size();
            end
            set_grid(rows, cols);
            nr = (rows > 64) ? 64 : int'(rows);
            nc = (cols > 64) ? 64 : int'(cols);
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(0, 24);
            repeat (PHASE_CELLS)
            begin
                // mostly cells inside the grid, some anywhere
                if (nr > 0 && $urandom_range(0, 4) != 0)
                    r = CELL_W'($urandom_range(0, nr - 1));
                else
                    r = CELL_W'($urandom_range(0, 63));
                if (nc > 0 && $urandom_range(0, 4) != 0)
                    c = CELL_W'($urandom_range(0, nc - 1));
                else
                    c = CELL_W'($urandom_range(0, 63));
                send_cell(r, c);
            end
            settle();
        end

        $display("Sent %0d cells and checked %0d results over %0d grid sizes",
                 cells_sent, checked, grids_set);
        $display("Sizes included empty, single-cell, single-row/column, full and saturated grids");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
